@@ sv/three_level_feedback_scheduler_unit_assert.svh @@
// Assertion macros for the three-level feedback scheduler.
// Used by the top level only; no other dependencies.
`ifndef THREE_LEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH
`define THREE_LEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TLFS_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tlfs assertion failed");
`define TLFS_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tlfs assertion failed");
`else
`define TLFS_ASSERT_IMP(name, clk, rstn, ante, cons)
`define TLFS_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

@@ sv/tlfs_pkg.sv @@
// Shared types and constants for the three-level feedback scheduler.
// No dependencies.
package tlfs_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PID_BITS    = 16;
    localparam int LEVELS      = 3;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_TERM = 2'd2;

    localparam logic [1:0] LVL_IDLE   = 2'd0;
    localparam logic [1:0] LVL_TOP    = 2'd1;
    localparam logic [1:0] LVL_MIDDLE = 2'd2;
    localparam logic [1:0] LVL_BOTTOM = 2'd3;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_IDLE = 2'd1;
    localparam logic [1:0] ERR_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [PID_BITS-1:0] pid;
        logic [1:0]          level;
    } req_t;

    typedef struct packed {
        logic [PID_BITS-1:0] running_pid;
        logic [1:0]          running_level;
        logic [PID_BITS-1:0] ended_pid;
        logic                ended_valid;
        logic [1:0]          error;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic exec;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

@@ sv/tlfs_ctrl.sv @@
// Controller for the three-level feedback scheduler: accept, settle, finish.
// Depends on tlfs_pkg.
module tlfs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  tlfs_pkg::status_t status,
    output tlfs_pkg::cmd_t    cmd
);
    import tlfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/tlfs_datapath.sv @@
// Datapath: level memories, pointers, counts, result register.
// Depends on tlfs_pkg.
module tlfs_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  tlfs_pkg::req_t    req,
    input  tlfs_pkg::cmd_t    cmd,
    output tlfs_pkg::status_t status,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output tlfs_pkg::rsp_t    rsp
);
    import tlfs_pkg::*;

    logic [PID_BITS-1:0] top_mem [QUEUE_DEPTH];
    logic [PID_BITS:0]   mid_mem [QUEUE_DEPTH];
    logic [PID_BITS-1:0] bot_mem [QUEUE_DEPTH];

    logic [PID_BITS-1:0] top_rd_reg;
    logic [PID_BITS:0]   mid_rd_reg;
    logic [PID_BITS-1:0] bot_rd_reg;

    logic [PTR_BITS-1:0] head_reg [LEVELS];
    logic [PTR_BITS-1:0] head_next [LEVELS];
    logic [PTR_BITS-1:0] tail_reg [LEVELS];
    logic [PTR_BITS-1:0] tail_next [LEVELS];
    logic [CNT_BITS-1:0] cnt_reg [LEVELS];
    logic [CNT_BITS-1:0] cnt_next [LEVELS];

    logic [LEVELS-1:0]   full;
    logic [LEVELS-1:0]   empty;
    logic [LEVELS-1:0]   push;
    logic [LEVELS-1:0]   pop;
    logic                age_set;

    logic [PID_BITS-1:0] mid_wpid;
    logic [PID_BITS-1:0] bot_wpid;
    logic [PTR_BITS-1:0] mid_waddr;
    logic [PID_BITS:0]   mid_wdata;

    logic [PID_BITS-1:0] ended_pid_reg;
    logic [PID_BITS-1:0] ended_pid_next;
    logic                ended_valid_reg;
    logic                ended_valid_next;
    logic [1:0]          err_reg;
    logic [1:0]          err_next;

    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            full[i]  = (cnt_reg[i] == CNT_BITS'(QUEUE_DEPTH));
            empty[i] = (cnt_reg[i] == '0);
        end
    end

    // operation decode on the accepted beat
    always_comb
    begin
        push             = '0;
        pop              = '0;
        age_set          = 1'b0;
        ended_pid_next   = '0;
        ended_valid_next = 1'b0;
        err_next         = ERR_NONE;
        case (req.mode)
            MODE_ENQ:
            begin
                case (req.level)
                    LVL_TOP:
                    begin
                        if (full[0]) err_next = ERR_FULL;
                        else         push[0]  = 1'b1;
                    end
                    LVL_MIDDLE:
                    begin
                        if (full[1]) err_next = ERR_FULL;
                        else         push[1]  = 1'b1;
                    end
                    LVL_BOTTOM:
                    begin
                        if (full[2]) err_next = ERR_FULL;
                        else         push[2]  = 1'b1;
                    end
                    default:
                    begin
                        err_next = ERR_NONE;
                    end
                endcase
            end
            MODE_TICK:
            begin
                if (!empty[0])
                begin
                    if (full[1])
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        push[1] = 1'b1;
                        pop[0]  = 1'b1;
                    end
                end
                else if (!empty[1])
                begin
                    if (mid_rd_reg[PID_BITS])
                    begin
                        if (full[2])
                        begin
                            err_next = ERR_FULL;
                        end
                        else
                        begin
                            push[2] = 1'b1;
                            pop[1]  = 1'b1;
                        end
                    end
                    else
                    begin
                        age_set = 1'b1;
                    end
                end
            end
            MODE_TERM:
            begin
                ended_valid_next = 1'b1;
                if (!empty[0])
                begin
                    ended_pid_next = top_rd_reg;
                    pop[0]         = 1'b1;
                end
                else if (!empty[1])
                begin
                    ended_pid_next = mid_rd_reg[PID_BITS-1:0];
                    pop[1]         = 1'b1;
                end
                else if (!empty[2])
                begin
                    ended_pid_next = bot_rd_reg;
                    pop[2]         = 1'b1;
                end
                else
                begin
                    ended_valid_next = 1'b0;
                    err_next         = ERR_IDLE;
                end
            end
            default:
            begin
                err_next = ERR_NONE;
            end
        endcase
    end

    assign mid_wpid  = (req.mode == MODE_TICK) ? top_rd_reg : req.pid;
    assign bot_wpid  = (req.mode == MODE_TICK) ? mid_rd_reg[PID_BITS-1:0] : req.pid;
    assign mid_waddr = push[1] ? tail_reg[1] : head_reg[1];
    assign mid_wdata = push[1] ? {1'b0, mid_wpid} : {1'b1, mid_rd_reg[PID_BITS-1:0]};

    // memories: head entry read every cycle, at most one write per beat
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push[0])
        begin
            top_mem[tail_reg[0]] <= req.pid;
        end
        if (cmd.exec && (push[1] || age_set))
        begin
            mid_mem[mid_waddr] <= mid_wdata;
        end
        if (cmd.exec && push[2])
        begin
            bot_mem[tail_reg[2]] <= bot_wpid;
        end
        top_rd_reg <= top_mem[head_reg[0]];
        mid_rd_reg <= mid_mem[head_reg[1]];
        bot_rd_reg <= bot_mem[head_reg[2]];
    end

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            cnt_next[i]  = cnt_reg[i];
            if (cmd.exec && push[i])
            begin
                tail_next[i] = (tail_reg[i] == PTR_BITS'(QUEUE_DEPTH - 1)) ?
                               '0 : tail_reg[i] + 1'b1;
            end
            if (cmd.exec && pop[i])
            begin
                head_next[i] = (head_reg[i] == PTR_BITS'(QUEUE_DEPTH - 1)) ?
                               '0 : head_reg[i] + 1'b1;
            end
            if (cmd.exec && push[i] && !pop[i])
            begin
                cnt_next[i] = cnt_reg[i] + 1'b1;
            end
            else if (cmd.exec && pop[i] && !push[i])
            begin
                cnt_next[i] = cnt_reg[i] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                cnt_reg[i]  <= cnt_next[i];
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ended_pid_reg   <= ended_pid_next;
            ended_valid_reg <= ended_valid_next;
            err_reg         <= err_next;
        end
        if (cmd.load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // running process from counts and refreshed head reads
    always_comb
    begin
        rsp_next             = '0;
        rsp_next.ended_pid   = ended_pid_reg;
        rsp_next.ended_valid = ended_valid_reg;
        rsp_next.error       = err_reg;
        if (!empty[0])
        begin
            rsp_next.running_pid   = top_rd_reg;
            rsp_next.running_level = LVL_TOP;
        end
        else if (!empty[1])
        begin
            rsp_next.running_pid   = mid_rd_reg[PID_BITS-1:0];
            rsp_next.running_level = LVL_MIDDLE;
        end
        else if (!empty[2])
        begin
            rsp_next.running_pid   = bot_rd_reg;
            rsp_next.running_level = LVL_BOTTOM;
        end
    end

    assign status.out_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid_next  = cmd.load || (rsp_valid_reg && rsp_stall);
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;

endmodule

@@ sv/three_level_feedback_scheduler_unit.sv @@
// Three-level feedback scheduler, top level. Depends on tlfs_pkg, tlfs_ctrl,
// tlfs_datapath and three_level_feedback_scheduler_unit_assert.svh.
// Result: offered after settle (head re-read) and finish, which waits while the
// result register is held; a new request is accepted only back in idle.
// Reset: asynchronous, clears pointers, counts and state; no clearing pass.
module three_level_feedback_scheduler_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  tlfs_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output tlfs_pkg::rsp_t   rsp
);
    import tlfs_pkg::*;
    `include "three_level_feedback_scheduler_unit_assert.svh"

    cmd_t    cmd;
    status_t status;
    logic    idle_err_beat;
    logic    idle_rsp_ok;

    tlfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tlfs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    assign idle_err_beat = rsp_valid && (rsp.error == ERR_IDLE);
    assign idle_rsp_ok   = (rsp.running_level == LVL_IDLE) && !rsp.ended_valid;

    `TLFS_ASSERT_NXT(a_exec_gap, clk, rst_n, cmd.exec, !cmd.exec && req_stall)
    `TLFS_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load, status.out_free && !cmd.exec)
    `TLFS_ASSERT_IMP(a_idle_err, clk, rst_n, idle_err_beat, idle_rsp_ok)
    `TLFS_ASSERT_IMP(a_ended_ok, clk, rst_n, rsp_valid && rsp.ended_valid, rsp.error == ERR_NONE)

endmodule

@@ test/tb_three_level_feedback_scheduler_unit.sv @@
// Testbench for three_level_feedback_scheduler_unit: directed, queue-full, back-pressure
// and random traffic, each result beat checked against a behavioural model of the levels.
// Depends on tlfs_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb_three_level_feedback_scheduler_unit;
    import tlfs_pkg::*;

    localparam logic [1:0] MODE_NOP = 2'd3;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   req_valid;
    logic   req_stall;
    req_t   req;
    logic   rsp_valid;
    logic   rsp_stall;
    rsp_t   rsp;

    // model of the three levels; middle entries carry an age bit
    logic [PID_BITS-1:0] top_lvl[$];
    logic [PID_BITS-1:0] mid_lvl[$];
    bit                  mid_aged[$];
    logic [PID_BITS-1:0] bot_lvl[$];

    rsp_t status_due[$];
    int   mismatches = 0;
    bit   tx_idle_en = 1'b1;
    bit   rx_idle_en = 1'b1;
    int   hold_req = 0;

    three_level_feedback_scheduler_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic rsp_t sched_advance(input req_t item);
        rsp_t res;
        res = '0;
        case (item.mode)
            MODE_ENQ:
            begin
                case (item.level)
                    LVL_TOP:
                        if (top_lvl.size() >= QUEUE_DEPTH)
                            res.error = ERR_FULL;
                        else
                            top_lvl.push_back(item.pid);
                    LVL_MIDDLE:
                        if (mid_lvl.size() >= QUEUE_DEPTH)
                            res.error = ERR_FULL;
                        else
                        begin
                            mid_lvl.push_back(item.pid);
                            mid_aged.push_back(1'b0);
                        end
                    LVL_BOTTOM:
                        if (bot_lvl.size() >= QUEUE_DEPTH)
                            res.error = ERR_FULL;
                        else
                            bot_lvl.push_back(item.pid);
                    default:
                        ;
                endcase
            end
            MODE_TICK:
            begin
                if (top_lvl.size() != 0)
                begin
                    if (mid_lvl.size() >= QUEUE_DEPTH)
                        res.error = ERR_FULL;
                    else
                    begin
                        mid_lvl.push_back(top_lvl.pop_front());
                        mid_aged.push_back(1'b0);
                    end
                end
                else if (mid_lvl.size() != 0)
                begin
                    if (!mid_aged[0])
                        mid_aged[0] = 1'b1;
                    else if (bot_lvl.size() >= QUEUE_DEPTH)
                        res.error = ERR_FULL;
                    else
                    begin
                        bot_lvl.push_back(mid_lvl.pop_front());
                        void'(mid_aged.pop_front());
                    end
                end
            end
            MODE_TERM:
            begin
                res.ended_valid = 1'b1;
                if (top_lvl.size() != 0)
                    res.ended_pid = top_lvl.pop_front();
                else if (mid_lvl.size() != 0)
                begin
                    res.ended_pid = mid_lvl.pop_front();
                    void'(mid_aged.pop_front());
                end
                else if (bot_lvl.size() != 0)
                    res.ended_pid = bot_lvl.pop_front();
                else
                begin
                    res.ended_valid = 1'b0;
                    res.error       = ERR_IDLE;
                end
            end
            default:
                ;
        endcase
        if (top_lvl.size() != 0)
        begin
            res.running_pid   = top_lvl[0];
            res.running_level = LVL_TOP;
        end
        else if (mid_lvl.size() != 0)
        begin
            res.running_pid   = mid_lvl[0];
            res.running_level = LVL_MIDDLE;
        end
        else if (bot_lvl.size() != 0)
        begin
            res.running_pid   = bot_lvl[0];
            res.running_level = LVL_BOTTOM;
        end
        else
            res.running_level = LVL_IDLE;
        return res;
    endfunction

    task automatic check_status(input rsp_t got);
        rsp_t want;
        if (status_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat %h", got);
            return;
        end
        want = status_due.pop_front();
        if (got.running_pid !== want.running_pid || got.running_level !== want.running_level ||
            got.ended_pid !== want.ended_pid || got.ended_valid !== want.ended_valid ||
            got.error !== want.error)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp run %h/%0d end %h/%0b err %0d, got run %h/%0d end %h/%0b err %0d",
                         want.running_pid, want.running_level, want.ended_pid,
                         want.ended_valid, want.error, got.running_pid, got.running_level,
                         got.ended_pid, got.ended_valid, got.error);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                check_status(rsp);
            if (req_valid && !req_stall)
                status_due.push_back(sched_advance(req));
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side pacing; a long hold is counted here
    initial
    begin : rsp_pacing
        int run_left;
        run_left = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
                run_left = 0;
                rsp_stall <= 1'b0;
            end
            else if (run_left > 0)
                run_left--;
            else if (!rx_idle_en)
                rsp_stall <= 1'b0;
            else if ($urandom_range(0, 2) == 0)
            begin
                rsp_stall <= 1'b1;
                run_left = idle_len() - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                run_left = $urandom_range(0, 7);
            end
        end
    end

    function automatic req_t make_req(input logic [1:0] m, input logic [PID_BITS-1:0] p,
                                      input logic [1:0] l);
        req_t r;
        r.mode  = m;
        r.pid   = p;
        r.level = l;
        return r;
    endfunction

    function automatic req_t random_req(input int w_enq, input int w_tick,
                                        input logic [1:0] home);
        int         r;
        logic [1:0] l;
        r = $urandom_range(0, 99);
        if (r < 4)
            return make_req(($urandom_range(0, 1) != 0) ? MODE_NOP : MODE_ENQ,
                            PID_BITS'($urandom), ($urandom_range(0, 1) != 0) ? LVL_IDLE : 2'($urandom));
        if (r < 4 + w_enq)
        begin
            l = ($urandom_range(0, 9) < 6) ? home : 2'($urandom_range(1, 3));
            return make_req(MODE_ENQ, PID_BITS'($urandom), l);
        end
        if (r < 4 + w_enq + w_tick)
            return make_req(MODE_TICK, PID_BITS'($urandom), 2'($urandom));
        return make_req(MODE_TERM, PID_BITS'($urandom), 2'($urandom));
    endfunction

    // one request beat; valid stays high into the next call unless a gap is drawn
    task automatic issue_request(input req_t item);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 2) == 0)
            gap = idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (status_due.size() != 0);
    endtask

    task automatic test_basic_ops();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        issue_request(make_req(MODE_TERM, 16'h0000, LVL_IDLE));
        issue_request(make_req(MODE_TICK, 16'hffff, LVL_BOTTOM));
        issue_request(make_req(MODE_ENQ, 16'hffff, LVL_IDLE));
        issue_request(make_req(MODE_NOP, 16'hffff, LVL_BOTTOM));
        issue_request(make_req(MODE_ENQ, 16'hffff, LVL_BOTTOM));
        issue_request(make_req(MODE_ENQ, 16'h0000, LVL_MIDDLE));
        issue_request(make_req(MODE_ENQ, 16'ha5a5, LVL_TOP));
        issue_request(make_req(MODE_ENQ, 16'h5a5a, LVL_TOP));
        issue_request(make_req(MODE_TICK, 16'h0000, LVL_IDLE));
        issue_request(make_req(MODE_TICK, 16'h0000, LVL_IDLE));
        issue_request(make_req(MODE_TICK, 16'h0000, LVL_IDLE));
        issue_request(make_req(MODE_TICK, 16'h0000, LVL_IDLE));
        issue_request(make_req(MODE_TICK, 16'h0000, LVL_IDLE));
        issue_request(make_req(MODE_ENQ, 16'h1234, LVL_TOP));
        issue_request(make_req(MODE_TERM, 16'hffff, LVL_BOTTOM));
        issue_request(make_req(MODE_TERM, 16'h0000, LVL_TOP));
        issue_request(make_req(MODE_TERM, 16'h0000, LVL_MIDDLE));
        issue_request(make_req(MODE_TERM, 16'h0000, LVL_IDLE));
        issue_request(make_req(MODE_TERM, 16'h0000, LVL_IDLE));
        issue_request(make_req(MODE_TERM, 16'hffff, LVL_IDLE));
        wait_drain();
    endtask

    task automatic test_queue_full();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (QUEUE_DEPTH + 1)
            issue_request(make_req(MODE_ENQ, PID_BITS'($urandom), LVL_BOTTOM));
        issue_request(make_req(MODE_ENQ, PID_BITS'($urandom), LVL_MIDDLE));
        // age the middle head, then fail to demote it into the full bottom level
        repeat (2)
            issue_request(make_req(MODE_TICK, PID_BITS'($urandom), 2'($urandom)));
        repeat (QUEUE_DEPTH)
            issue_request(make_req(MODE_ENQ, PID_BITS'($urandom), LVL_MIDDLE));
        repeat (QUEUE_DEPTH + 1)
            issue_request(make_req(MODE_ENQ, PID_BITS'($urandom), LVL_TOP));
        issue_request(make_req(MODE_TICK, PID_BITS'($urandom), 2'($urandom)));
        repeat (3 * QUEUE_DEPTH + 1)
            issue_request(make_req(MODE_TERM, PID_BITS'($urandom), 2'($urandom)));
        wait_drain();
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        hold_req   = 400;
        repeat (60)
            issue_request(random_req(70, 15, LVL_MIDDLE));
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int         sent;
        int         burst;
        int         w_enq;
        int         w_tick;
        logic [1:0] home;
        sent = 0;
        while (sent < 750)
        begin
            burst      = $urandom_range(20, 150);
            w_enq      = $urandom_range(20, 85);
            w_tick     = $urandom_range(0, 96 - w_enq);
            home       = 2'($urandom_range(1, 3));
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            repeat (burst)
                issue_request(random_req(w_enq, w_tick, home));
            sent += burst;
            if ($urandom_range(0, 3) == 0)
                wait_drain();
        end
        wait_drain();
    endtask

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        req_valid <= 1'b0;
        req       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_ops();
        test_queue_full();
        test_backpressure();
        test_random_traffic();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && status_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
